@@ rtl/core/poly_saw_carrier_voices_top_defines.svh @@
// Assertion helpers for the carrier block.
// PSC_ASSERT checks on clk and is switched off while rst_n is low.
// PSC_ASSERT_NR checks on clk at every edge, including during reset.
`ifndef POLY_SAW_CARRIER_VOICES_TOP_DEFINES_SVH
`define POLY_SAW_CARRIER_VOICES_TOP_DEFINES_SVH
`ifndef SYNTHESIS
`define PSC_ASSERT(lbl, clk_i, rstn_i, prop, msg) \
    lbl: assert property (@(posedge clk_i) disable iff (!rstn_i) prop) else $error(msg);
`define PSC_ASSERT_NR(lbl, clk_i, prop, msg) \
    lbl: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define PSC_ASSERT(lbl, clk_i, rstn_i, prop, msg)
`define PSC_ASSERT_NR(lbl, clk_i, prop, msg)
`endif
`endif

@@ rtl/core/psc_pkg.sv @@
`timescale 1ns / 1ps
package psc_pkg;

    localparam int NUM_VOICES_DEF  = 8;
    localparam int QUEUE_DEPTH_DEF = 4;

    // beat layout
    localparam int IN_DATA_W  = 16;  // note_number, note_velocity, pad
    localparam int IN_USER_W  = 2;   // req_type
    localparam int OUT_DATA_W = 24;  // carrier_sample

    // request codes on tuser
    localparam logic [1:0] REQ_NOTE_ON  = 2'd0;
    localparam logic [1:0] REQ_NOTE_OFF = 2'd1;
    localparam logic [1:0] REQ_TICK     = 2'd2;

    // configuration register indexes
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 31;
    localparam logic [CFG_IDX_W-1:0] CFG_A4_INCREMENT  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CARRIER_LEVEL = 1'd1;

    localparam logic [30:0] A4_INC_RESET = 31'd39370534;
    localparam logic [15:0] LEVEL_RESET  = 16'd32768;

    // arithmetic widths
    localparam int INC_PROD_W = 62;  // 31 x 31 bit increment product
    localparam int SAW_PROD_W = 31;  // Q1.23 saw times 7 bit velocity
    localparam int AVG_W      = 25;  // |average| <= 2^23
    localparam int SCL_W      = 42;  // average times 17 bit signed level
    localparam int AVG_LIMIT  = 8388608;
    localparam int LEVEL_SHIFT = 15;
    // shift = 30 - octave, octave = (note + 3) / 12 - 6
    localparam logic [5:0] INC_SHIFT_BASE = 6'd36;

    typedef enum logic [1:0] {
        OP_ON,
        OP_OFF,
        OP_TICK
    } op_t;

    typedef struct packed {
        op_t        op;
        logic [6:0] note;
        logic [6:0] vel;
    } op_item_t;

    typedef struct packed {
        logic [30:0] a4_inc;
        logic [15:0] level;
    } cfg_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_OFF,
        ST_ON_MUL,
        ST_ON_WRITE,
        ST_WALK,
        ST_DIV_INIT,
        ST_DIV,
        ST_SCALE,
        ST_SAT,
        ST_OUT
    } st_t;

    // Q1.30 semitone ratios, round(2^30 * 2^(k/12))
    function automatic logic [30:0] semi_ratio(input logic [3:0] k);
        logic [30:0] r;
        case (k)
            4'd0:    r = 31'd1073741824;
            4'd1:    r = 31'd1137589836;
            4'd2:    r = 31'd1205234447;
            4'd3:    r = 31'd1276901417;
            4'd4:    r = 31'd1352829926;
            4'd5:    r = 31'd1433273380;
            4'd6:    r = 31'd1518500250;
            4'd7:    r = 31'd1608794974;
            4'd8:    r = 31'd1704458901;
            4'd9:    r = 31'd1805811301;
            4'd10:   r = 31'd1913190429;
            4'd11:   r = 31'd2026954652;
            default: r = '0;
        endcase
        return r;
    endfunction

    // n / 12 for n in 0..130, by threshold compares
    function automatic logic [3:0] note_octave(input logic [7:0] n);
        logic [3:0] q;
        q = '0;
        for (int j = 1; j <= 10; j++) begin
            if (n >= 8'(12 * j)) begin
                q = 4'(j);
            end
        end
        return q;
    endfunction

endpackage

@@ rtl/core/poly_saw_carrier_voices_top.sv @@
`timescale 1ns / 1ps
// Ops run one at a time: a note-on passes ST_ON_MUL and ST_ON_WRITE, a note-off ST_OFF; a tick
//   walks the voices, divides over ACC_W = 31 + clog2(NUM_VOICES+1) bits, scales and saturates.
// Throughput: one item in flight in the voice engine; a tick walks one voice per cycle and the divider
//   makes one bit per cycle; a note-on that finds the pool full skips ST_ON_WRITE.
// Reset (rst_n, async, low): all voices idle, queue and output empty, registers to defaults.
module poly_saw_carrier_voices_top #(
    parameter int NUM_VOICES  = psc_pkg::NUM_VOICES_DEF,
    parameter int QUEUE_DEPTH = psc_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    // request beat
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [psc_pkg::IN_DATA_W-1:0]  s_tdata,   // [6:0] note_number, [13:7] note_velocity
    input  logic [psc_pkg::IN_USER_W-1:0]  s_tuser,   // [1:0] req_type
    // sample beat
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [psc_pkg::OUT_DATA_W-1:0] m_tdata,   // [23:0] carrier_sample
    // register writes
    input  logic                           cfg_we,
    input  logic [psc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [psc_pkg::CFG_DATA_W-1:0] cfg_wdata
);
    import psc_pkg::*;

    // Front decodes each request beat into an op (velocity-zero note-on
    // becomes a release, the unused code is dropped) and pushes it into a
    // short queue. The back end pops ops one at a time and runs them on the
    // voice pool: note events search/clear the active bits, a tick walks the
    // voices, sums velocity-weighted saws, divides by 127*count bit-serially,
    // applies the level and saturates. The result sits in an output register
    // so the back end keeps working while the sink stalls; a second sample waits in ST_OUT.

    cfg_t     cfg_reg, cfg_next;
    logic     q_push, q_pop, q_full, q_empty;
    op_item_t q_in, q_head;

    // register file
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_A4_INCREMENT:  cfg_next.a4_inc = cfg_wdata;
                CFG_CARRIER_LEVEL: cfg_next.level  = cfg_wdata[15:0];
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.a4_inc <= A4_INC_RESET;
            cfg_reg.level  <= LEVEL_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    psc_front u_front (
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .q_full    (q_full),
        .push      (q_push),
        .push_item (q_in)
    );

    psc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_item (q_in),
        .pop       (q_pop),
        .head      (q_head),
        .full      (q_full),
        .empty     (q_empty)
    );

    psc_back #(
        .NUM_VOICES (NUM_VOICES)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .q_empty  (q_empty),
        .q_head   (q_head),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

@@ rtl/core/psc_front.sv @@
`timescale 1ns / 1ps
module psc_front (
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [psc_pkg::IN_DATA_W-1:0] s_tdata,
    input  logic [psc_pkg::IN_USER_W-1:0] s_tuser,
    input  logic                          q_full,
    output logic                          push,
    output psc_pkg::op_item_t             push_item
);
    import psc_pkg::*;

    logic keep;

    assign s_tready = !q_full;

    always_comb
    begin
        push_item.note = s_tdata[6:0];
        push_item.vel  = s_tdata[13:7];
        push_item.op   = OP_TICK;
        keep           = 1'b1;
        unique case (s_tuser)
            REQ_NOTE_ON:
            begin
                // zero velocity is a release
                push_item.op = (s_tdata[13:7] == 7'd0) ? OP_OFF : OP_ON;
            end
            REQ_NOTE_OFF: push_item.op = OP_OFF;
            REQ_TICK:     push_item.op = OP_TICK;
            default:      keep = 1'b0;
        endcase
    end

    assign push = s_tvalid && !q_full && keep;

endmodule

@@ rtl/core/psc_queue.sv @@
`timescale 1ns / 1ps
`include "poly_saw_carrier_voices_top_defines.svh"
module psc_queue #(
    parameter int DEPTH = psc_pkg::QUEUE_DEPTH_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  psc_pkg::op_item_t push_item,
    input  logic              pop,
    output psc_pkg::op_item_t head,
    output logic              full,
    output logic              empty
);
    import psc_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);

    op_item_t         entry_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign head    = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

    `PSC_ASSERT_NR(a_count_bound, clk, count_reg <= CNT_W'(DEPTH), "queue count past depth")
    `PSC_ASSERT(a_push_grows, clk, rst_n, (push && !pop && !full) |=> (count_reg == $past(count_reg) + 1'b1), "push lost")
    `PSC_ASSERT(a_pop_has_data, clk, rst_n, pop |-> !empty, "pop from empty queue")

endmodule

@@ rtl/core/psc_back.sv @@
`timescale 1ns / 1ps
`include "poly_saw_carrier_voices_top_defines.svh"
module psc_back #(
    parameter int NUM_VOICES = psc_pkg::NUM_VOICES_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  psc_pkg::cfg_t                  cfg,
    input  logic                           q_empty,
    input  psc_pkg::op_item_t              q_head,
    output logic                           q_pop,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [psc_pkg::OUT_DATA_W-1:0] m_tdata
);
    import psc_pkg::*;

    localparam int VW    = (NUM_VOICES > 1) ? $clog2(NUM_VOICES) : 1;
    localparam int CW    = $clog2(NUM_VOICES + 1);
    localparam int ACC_W = SAW_PROD_W + CW;
    localparam int DIV_W = CW + 7;
    localparam int DC_W  = $clog2(ACC_W);
    localparam logic [VW-1:0] LAST_VOICE = VW'(NUM_VOICES - 1);
    localparam logic signed [SCL_W-1:0] SAT_HI = SCL_W'(8388607);
    localparam logic signed [SCL_W-1:0] SAT_LO = SCL_W'(-8388608);

    st_t state_reg, state_next;
    op_item_t cur_reg, cur_next;

    logic [NUM_VOICES-1:0] active_reg, active_next;
    logic [6:0]            voice_note_reg  [NUM_VOICES];
    logic [6:0]            voice_vel_reg   [NUM_VOICES];
    logic [31:0]           voice_phase_reg [NUM_VOICES];
    logic [31:0]           voice_inc_reg   [NUM_VOICES];
    logic                  voice_we, phase_we;

    logic [VW-1:0] idx_reg, idx_next;
    logic [VW-1:0] free_idx_reg, free_idx_next;
    logic [VW-1:0] free_idx;
    logic          any_free;

    logic [INC_PROD_W-1:0] prod_reg, prod_next;
    logic [5:0]            sh_reg, sh_next;
    logic [7:0]            n8;
    logic [3:0]            oct;
    logic [3:0]            semi;
    logic [31:0]           inc_val;

    logic signed [ACC_W-1:0]      acc_reg, acc_next;
    logic [CW-1:0]                cnt_reg, cnt_next;
    logic signed [23:0]           saw;
    logic signed [SAW_PROD_W-1:0] saw_prod;

    logic [ACC_W-1:0] dvd_reg, dvd_next;
    logic [DIV_W-1:0] rem_reg, rem_next;
    logic [DIV_W-1:0] dsr_reg, dsr_next;
    logic             neg_reg, neg_next;
    logic [DC_W-1:0]  dc_reg, dc_next;
    logic [DIV_W:0]   rem_sh, rem_sub;
    logic             q_bit;
    logic [ACC_W-1:0] mag;

    logic [AVG_W-1:0]        avg_mag;
    logic signed [AVG_W-1:0] avg;
    logic signed [SCL_W-1:0] scl_reg, scl_next;
    logic signed [SCL_W-1:0] scl_sh;
    logic signed [23:0]      res_reg, res_next;

    logic        out_valid_reg, out_valid_next;
    logic [23:0] out_data_reg, out_data_next;

    // increment path
    assign n8      = {1'b0, cur_reg.note} + 8'd3;
    assign oct     = note_octave(n8);
    assign semi    = 4'(n8 - 8'(oct) * 8'd12);
    assign inc_val = 32'(prod_reg >> sh_reg);

    // lowest free voice
    always_comb
    begin
        free_idx = '0;
        any_free = ~&active_reg;
        for (int i = NUM_VOICES - 1; i >= 0; i--)
        begin
            if (!active_reg[i])
            begin
                free_idx = VW'(i);
            end
        end
    end

    // saw of the walked voice, Q1.23
    assign saw = $signed({~voice_phase_reg[idx_reg][31], voice_phase_reg[idx_reg][30:8]});
    assign saw_prod = SAW_PROD_W'(saw)
                    * SAW_PROD_W'($signed({1'b0, voice_vel_reg[idx_reg]}));

    // one restoring divide step
    assign rem_sh  = {rem_reg, dvd_reg[ACC_W-1]};
    assign q_bit   = (rem_sh >= {1'b0, dsr_reg});
    assign rem_sub = q_bit ? rem_sh - {1'b0, dsr_reg} : rem_sh;
    assign mag     = acc_reg[ACC_W-1] ? ACC_W'(-acc_reg) : ACC_W'(acc_reg);

    assign avg_mag = AVG_W'(dvd_reg);
    assign avg     = neg_reg ? -$signed(avg_mag) : $signed(avg_mag);
    assign scl_sh  = scl_reg >>> LEVEL_SHIFT;

    assign q_pop = (state_reg == ST_IDLE) && !q_empty;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (!q_empty)
                begin
                    unique case (q_head.op)
                        OP_ON:   state_next = ST_ON_MUL;
                        OP_OFF:  state_next = ST_OFF;
                        OP_TICK: state_next = ST_WALK;
                        default: state_next = ST_IDLE;
                    endcase
                end
            end
            ST_OFF:      state_next = ST_IDLE;
            ST_ON_MUL:   state_next = any_free ? ST_ON_WRITE : ST_IDLE;
            ST_ON_WRITE: state_next = ST_IDLE;
            ST_WALK:
            begin
                if (idx_reg == LAST_VOICE)
                begin
                    state_next = ST_DIV_INIT;
                end
            end
            ST_DIV_INIT: state_next = (cnt_reg == '0) ? ST_OUT : ST_DIV;
            ST_DIV:
            begin
                if (dc_reg == '0)
                begin
                    state_next = ST_SCALE;
                end
            end
            ST_SCALE: state_next = ST_SAT;
            ST_SAT:   state_next = ST_OUT;
            ST_OUT:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // datapath
    always_comb
    begin
        cur_next       = cur_reg;
        active_next    = active_reg;
        voice_we       = 1'b0;
        phase_we       = 1'b0;
        idx_next       = idx_reg;
        free_idx_next  = free_idx_reg;
        prod_next      = prod_reg;
        sh_next        = sh_reg;
        acc_next       = acc_reg;
        cnt_next       = cnt_reg;
        dvd_next       = dvd_reg;
        rem_next       = rem_reg;
        dsr_next       = dsr_reg;
        neg_next       = neg_reg;
        dc_next        = dc_reg;
        scl_next       = scl_reg;
        res_next       = res_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;

        if (out_valid_reg && m_tready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (!q_empty)
                begin
                    cur_next = q_head;
                    idx_next = '0;
                    acc_next = '0;
                    cnt_next = '0;
                end
            end
            ST_OFF:
            begin
                for (int i = 0; i < NUM_VOICES; i++)
                begin
                    if (active_reg[i] && (voice_note_reg[i] == cur_reg.note))
                    begin
                        active_next[i] = 1'b0;
                    end
                end
            end
            ST_ON_MUL:
            begin
                prod_next     = INC_PROD_W'(cfg.a4_inc) * INC_PROD_W'(semi_ratio(semi));
                sh_next       = INC_SHIFT_BASE - {2'b00, oct};
                free_idx_next = free_idx;
            end
            ST_ON_WRITE:
            begin
                voice_we = 1'b1;
                active_next[free_idx_reg] = 1'b1;
            end
            ST_WALK:
            begin
                if (active_reg[idx_reg])
                begin
                    acc_next = acc_reg + ACC_W'(saw_prod);
                    cnt_next = cnt_reg + 1'b1;
                    phase_we = 1'b1;
                end
                idx_next = (idx_reg == LAST_VOICE) ? '0 : idx_reg + 1'b1;
            end
            ST_DIV_INIT:
            begin
                if (cnt_reg == '0)
                begin
                    res_next = '0;
                end
                else
                begin
                    dvd_next = mag;
                    rem_next = '0;
                    dsr_next = DIV_W'({cnt_reg, 7'b0}) - DIV_W'(cnt_reg);
                    neg_next = acc_reg[ACC_W-1];
                    dc_next  = DC_W'(ACC_W - 1);
                end
            end
            ST_DIV:
            begin
                rem_next = DIV_W'(rem_sub);
                dvd_next = {dvd_reg[ACC_W-2:0], q_bit};
                dc_next  = dc_reg - 1'b1;
            end
            ST_SCALE:
            begin
                scl_next = SCL_W'(avg) * SCL_W'($signed({1'b0, cfg.level}));
            end
            ST_SAT:
            begin
                if (scl_sh > SAT_HI)
                begin
                    res_next = 24'(SAT_HI);
                end
                else if (scl_sh < SAT_LO)
                begin
                    res_next = 24'(SAT_LO);
                end
                else
                begin
                    res_next = 24'(scl_sh);
                end
            end
            ST_OUT:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = res_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            active_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            active_reg    <= active_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg      <= cur_next;
        idx_reg      <= idx_next;
        free_idx_reg <= free_idx_next;
        prod_reg     <= prod_next;
        sh_reg       <= sh_next;
        acc_reg      <= acc_next;
        cnt_reg      <= cnt_next;
        dvd_reg      <= dvd_next;
        rem_reg      <= rem_next;
        dsr_reg      <= dsr_next;
        neg_reg      <= neg_next;
        dc_reg       <= dc_next;
        scl_reg      <= scl_next;
        res_reg      <= res_next;
        out_data_reg <= out_data_next;
    end

    always_ff @(posedge clk)
    begin
        if (voice_we)
        begin
            voice_note_reg[free_idx_reg]  <= cur_reg.note;
            voice_vel_reg[free_idx_reg]   <= cur_reg.vel;
            voice_phase_reg[free_idx_reg] <= '0;
            voice_inc_reg[free_idx_reg]   <= inc_val;
        end
        if (phase_we)
        begin
            voice_phase_reg[idx_reg] <= voice_phase_reg[idx_reg] + voice_inc_reg[idx_reg];
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    `PSC_ASSERT(a_slot_free, clk, rst_n, (state_reg == ST_ON_WRITE) |-> !active_reg[free_idx_reg], "note-on slot taken")
    `PSC_ASSERT(a_slot_set, clk, rst_n, (state_reg == ST_ON_WRITE) |=> active_reg[$past(free_idx_reg)], "note-on slot not set")
    `PSC_ASSERT(a_div_sane, clk, rst_n, (state_reg == ST_DIV) |-> ((dsr_reg != '0) && (rem_reg < dsr_reg)), "divider state bad")
    `PSC_ASSERT(a_avg_range, clk, rst_n, (state_reg == ST_SCALE) |-> (dvd_reg <= ACC_W'(AVG_LIMIT)), "average out of range")

endmodule
